/* design/bpowv_pkg.sv */
// Package for the block proof-of-work validator: beat types, constants and CRC-32 matrix.
package bpowv_pkg;

  localparam int unsigned HDR_BITS = 192;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_FULL = 32'hFFFF_FFFF;
  localparam logic [5:0]  DIFF_MIN = 6'd1;
  localparam logic [5:0]  DIFF_MAX = 6'd32;

  typedef struct packed {
    logic signed [31:0] block_height;
    logic [31:0]        block_time;
    logic [31:0]        previous_hash;
    logic [31:0]        header_difficulty;
    logic [31:0]        nonce_word;
    logic [31:0]        miner_id;
    logic [31:0]        claimed_hash;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               stale;
    logic               hash_mismatch;
    logic [31:0]        computed_hash;
    logic [5:0]         next_difficulty;
    logic signed [31:0] tip_height_out;
  } out_item_t;

  // Hash unit to chain unit.
  typedef struct packed {
    logic [31:0] computed_hash;
    logic        hash_mismatch;
    logic        meets_target;
  } hash_res_t;

  // Chain unit back to the top level.
  typedef struct packed {
    logic               accepted;
    logic               stale;
    logic [5:0]         next_difficulty;
    logic signed [31:0] tip_height;
  } chain_res_t;

  // Row j holds the header bits that feed bit j of the CRC.
  typedef logic [31:0][HDR_BITS-1:0] crc_mat_t;

  // Bit-serial reflected CRC over the header, bit 0 first. Used only at elaboration.
  function automatic logic [31:0] crc_serial(input logic [HDR_BITS-1:0] d,
                                             input logic [31:0] init);
    logic [31:0] c;
    logic        fb;
    c = init;
    for (int k = 0; k < HDR_BITS; k++) begin
      fb = c[0] ^ d[k];
      c  = (c >> 1) ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic crc_mat_t crc_matrix();
    crc_mat_t                m;
    logic [31:0]             col;
    logic [HDR_BITS-1:0]     one;
    one = {{(HDR_BITS-1){1'b0}}, 1'b1};
    m   = '0;
    for (int i = 0; i < HDR_BITS; i++) begin
      col = crc_serial(one << i, 32'h0);
      for (int j = 0; j < 32; j++) begin
        m[j][i] = col[j];
      end
    end
    return m;
  endfunction

  // The CRC is affine in the header bits: a fixed matrix plus a fixed offset.
  localparam crc_mat_t    CRC_MAT = crc_matrix();
  localparam logic [31:0] CRC_OFS = crc_serial({HDR_BITS{1'b0}}, CRC_FULL) ^ CRC_FULL;

endpackage

/* design/bpowv_hash.sv */
// CRC-32 over the 24 header bytes, claimed hash compare and difficulty target check.
module bpowv_hash
  import bpowv_pkg::*;
(
  input  in_item_t  item,
  output hash_res_t res
);

  logic [HDR_BITS-1:0] hdr_bits;
  logic [31:0]         crc;
  logic [5:0]          target_bits;
  logic [31:0]         target_mask;

  // Words are little-endian and the CRC is reflected, so the stream is word 0 bit 0 upward.
  assign hdr_bits = {item.miner_id, item.nonce_word, item.header_difficulty,
                     item.previous_hash, item.block_time, item.block_height};

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      crc[j] = CRC_OFS[j] ^ (^(hdr_bits & CRC_MAT[j]));
    end
  end

  always_comb begin
    if ((|item.header_difficulty[31:6]) || (item.header_difficulty[5:0] > DIFF_MAX)) begin
      target_bits = DIFF_MAX;
    end else begin
      target_bits = item.header_difficulty[5:0];
    end
    // A zero difficulty still requires the top bit to be clear.
    if (target_bits == 6'd0) begin
      target_mask = 32'h8000_0000;
    end else begin
      target_mask = ~(CRC_FULL >> target_bits);
    end
  end

  assign res.computed_hash = crc;
  assign res.hash_mismatch = (crc != item.claimed_hash);
  assign res.meets_target  = ((crc & target_mask) == 32'h0);

endmodule

/* design/bpowv_chain.sv */
// Chain state: tip height and global difficulty, with the accept and retarget decision.
module bpowv_chain
  import bpowv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               commit,
  input  logic signed [31:0] block_height,
  input  logic               meets_target,
  output chain_res_t         res
);

  logic signed [31:0] tip_r, tip_nxt;
  logic [5:0]         diff_r, diff_nxt;
  logic [5:0]         diff_after;
  logic signed [31:0] tip_after;
  logic               stale;
  logic               accepted;
  logic               mult_ten;
  logic [6:0]         nib_sum;
  logic [4:0]         fold1;
  logic [3:0]         fold2;
  logic [2:0]         rem5;
  logic [5:0]         cfg_sat;

  // Divisible by ten means even and divisible by five. Since 16 is 1 mod 5 the nibble
  // sum keeps the residue; a negative value reads 2^32 too high, which is 1 mod 5.
  always_comb begin
    nib_sum = 7'd0;
    for (int n = 0; n < 8; n++) begin
      nib_sum = nib_sum + {3'd0, block_height[4*n +: 4]};
    end
    fold1 = {2'd0, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
    fold2 = {3'd0, fold1[4]} + fold1[3:0];
    if (fold2 == 4'd15) begin
      rem5 = 3'd0;
    end else if (fold2 >= 4'd10) begin
      rem5 = 3'(fold2 - 4'd10);
    end else if (fold2 >= 4'd5) begin
      rem5 = 3'(fold2 - 4'd5);
    end else begin
      rem5 = 3'(fold2);
    end
    mult_ten = !block_height[0] && (rem5 == {2'd0, block_height[31]});
  end

  always_comb begin
    stale    = (tip_r >= block_height);
    accepted = !stale && meets_target;
    tip_after  = accepted ? block_height : tip_r;
    diff_after = diff_r;
    if (accepted && mult_ten && (diff_r < DIFF_MAX)) begin
      diff_after = diff_r + 6'd1;
    end
  end

  always_comb begin
    if (cfg_wr_data < DIFF_MIN) begin
      cfg_sat = DIFF_MIN;
    end else if (cfg_wr_data > DIFF_MAX) begin
      cfg_sat = DIFF_MAX;
    end else begin
      cfg_sat = cfg_wr_data;
    end
  end

  always_comb begin
    tip_nxt  = tip_r;
    diff_nxt = diff_r;
    if (cfg_wr_en) begin
      diff_nxt = cfg_sat;
    end else if (commit) begin
      tip_nxt  = tip_after;
      diff_nxt = diff_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_r  <= '0;
      diff_r <= DIFF_MIN;
    end else begin
      tip_r  <= tip_nxt;
      diff_r <= diff_nxt;
    end
  end

  assign res.accepted        = accepted;
  assign res.stale           = stale;
  assign res.next_difficulty = diff_after;
  assign res.tip_height      = tip_after;

endmodule

/* design/block_proof_of_work_validator_unit.sv */
// Top level of the block proof-of-work validator.
// Each input beat on in_data carries one block header. The unit hashes it with CRC-32
// over 24 little-endian bytes, flags a mismatch with the claimed hash, checks the
// height against the kept tip and the hash against the header difficulty, and
// returns one result beat on out_data with the updated tip height and difficulty.
// A beat is taken on an edge with valid high and stall low, on either channel.
// The header lands in the input register, then a single pass of combinational logic
// feeds the result register, which drives out_valid. Throughput is one header per
// cycle while out_stall is low; the tip and difficulty registers update together
// with the result register.
// While out_stall holds, the result register keeps its beat and one more header may
// still be taken into the input register; then in_stall rises.
// cfg_wr_en loads cfg_wr_data, saturated to 1..32, as the global difficulty; write it
// only while no header is in flight.
// Synchronous reset clears both registers' valid flags, sets the tip height to zero
// and the difficulty to one.
module block_proof_of_work_validator_unit
  import bpowv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  logic       s1_vld_r, s1_vld_nxt;
  in_item_t   s1_data_r;
  logic       out_vld_r, out_vld_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       advance;
  logic       in_take;
  hash_res_t  hash_res;
  chain_res_t chain_res;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bpowv_hash u_hash (
    .item (s1_data_r),
    .res  (hash_res)
  );

  bpowv_chain u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .commit       (s1_vld_r && advance),
    .block_height (s1_data_r.block_height),
    .meets_target (hash_res.meets_target),
    .res          (chain_res)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = advance ? s1_vld_r : out_vld_r;
    out_data_nxt.accepted        = chain_res.accepted;
    out_data_nxt.stale           = chain_res.stale;
    out_data_nxt.hash_mismatch   = hash_res.hash_mismatch;
    out_data_nxt.computed_hash   = hash_res.computed_hash;
    out_data_nxt.next_difficulty = chain_res.next_difficulty;
    out_data_nxt.tip_height_out  = chain_res.tip_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_vld_r && advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* design/bpowv_checker.sv */
// Port-level checker for the validator, bound to the top level.
module bpowv_checker
  import bpowv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input out_item_t  out_data,
  input logic       cfg_wr_en
);

  logic               out_beat;
  logic               have_prev_r;
  logic signed [31:0] prev_tip_r;
  logic [5:0]         prev_diff_r;

  assign out_beat = out_valid && !out_stall;

  // Track the state reported by the last result beat since reset or a config write.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      have_prev_r <= 1'b0;
    end else if (out_beat) begin
      have_prev_r <= 1'b1;
    end
    if (out_beat) begin
      prev_tip_r  <= out_data.tip_height_out;
      prev_diff_r <= out_data.next_difficulty;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_accept_not_stale: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> !(out_data.accepted && out_data.stale))
    else $error("block both accepted and stale");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && have_prev_r && !out_data.accepted |->
      out_data.tip_height_out == prev_tip_r && out_data.next_difficulty == prev_diff_r)
    else $error("rejected block changed chain state");

  a_tip_rises: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && have_prev_r && out_data.accepted |-> out_data.tip_height_out > prev_tip_r)
    else $error("accepted block did not raise the tip height");

  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> out_data.next_difficulty >= DIFF_MIN && out_data.next_difficulty <= DIFF_MAX)
    else $error("difficulty out of range");

endmodule

bind block_proof_of_work_validator_unit bpowv_checker u_bpowv_checker (.*);

/* tb/tb_block_proof_of_work_validator_unit.sv */
// Self-checking testbench for the proof-of-work validator: CRC-32 header check and chain tip.
`timescale 1ns / 100ps

module tb_block_proof_of_work_validator_unit;
  import bpowv_pkg::*;

  localparam logic [31:0] GEN_POLY  = 32'hEDB8_8320;
  localparam int          ROWS      = 21;
  localparam int          HEAD_ROWS = 17;
  localparam int          PHASES    = 8;
  localparam int          PER_PHASE = 230;
  localparam int          DRAIN_CYC = 4;

  typedef struct {
    in_item_t           hdr;
    bit                 forge;
    logic [31:0]        want;
    bit                 known;
    logic               k_acc;
    logic               k_stale;
    logic [5:0]         k_diff;
    logic signed [31:0] k_tip;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  // Predicted chain state and the results still owed by the block.
  logic signed [31:0] chain_tip = '0;
  logic [5:0]         chain_diff = DIFF_MIN;
  out_item_t          verdict_q[$];
  int                 mismatches = 0;
  bit                 calm = 1'b0;
  int                 stall_left = 0;
  row_t               plan [ROWS];

  block_proof_of_work_validator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // A reflected CRC absorbs a little-endian word as one XOR followed by 32 shifts.
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [31:0] w);
    c = c ^ w;
    for (int k = 0; k < 32; k++) c = c[0] ? ((c >> 1) ^ GEN_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] header_crc(input in_item_t h);
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    c = crc_feed(c, h.block_height);
    c = crc_feed(c, h.block_time);
    c = crc_feed(c, h.previous_hash);
    c = crc_feed(c, h.header_difficulty);
    c = crc_feed(c, h.nonce_word);
    c = crc_feed(c, h.miner_id);
    return ~c;
  endfunction

  // Picks the miner id that makes the header hash to the wanted value by running the
  // last 32 shifts backwards from the wanted final register.
  function automatic logic [31:0] steer_miner(input in_item_t h, input logic [31:0] want);
    logic [31:0] c;
    logic [31:0] r;
    c = 32'hFFFF_FFFF;
    c = crc_feed(c, h.block_height);
    c = crc_feed(c, h.block_time);
    c = crc_feed(c, h.previous_hash);
    c = crc_feed(c, h.header_difficulty);
    c = crc_feed(c, h.nonce_word);
    r = ~want;
    for (int k = 0; k < 32; k++) r = r[31] ? (((r ^ GEN_POLY) << 1) | 32'h1) : (r << 1);
    return r ^ c;
  endfunction

  function automatic bit clears_target(input logic [31:0] hv, input logic [31:0] hd);
    logic [5:0] d;
    d = (hd > 32'(DIFF_MAX)) ? DIFF_MAX : hd[5:0];
    if (d == 6'd0) return !hv[31];
    return (hv >> (32 - d)) == 32'h0;
  endfunction

  function automatic void judge_header(input in_item_t h, output out_item_t v);
    logic [31:0] hv;
    hv = header_crc(h);
    v.stale = (h.block_height <= chain_tip);
    v.accepted = !v.stale && clears_target(hv, h.header_difficulty);
    if (v.accepted) begin
      chain_tip = h.block_height;
      if ((h.block_height % 32'sd10) == 0 && chain_diff < DIFF_MAX) chain_diff++;
    end
    v.hash_mismatch = (hv != h.claimed_hash);
    v.computed_hash = hv;
    v.next_difficulty = chain_diff;
    v.tip_height_out = chain_tip;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Appends one prediction to the queue of results still owed.
  task automatic post_verdict(input out_item_t v);
    verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic compare_beat(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch("unexpected result beat", got.computed_hash, '0);
      return;
    end
    want = verdict_q.pop_front();
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.stale !== want.stale)
      report_mismatch("stale", 32'(got.stale), 32'(want.stale));
    if (got.hash_mismatch !== want.hash_mismatch)
      report_mismatch("hash_mismatch", 32'(got.hash_mismatch), 32'(want.hash_mismatch));
    if (got.computed_hash !== want.computed_hash)
      report_mismatch("computed_hash", got.computed_hash, want.computed_hash);
    if (got.next_difficulty !== want.next_difficulty)
      report_mismatch("next_difficulty", 32'(got.next_difficulty), 32'(want.next_difficulty));
    if (got.tip_height_out !== want.tip_height_out)
      report_mismatch("tip_height_out", got.tip_height_out, want.tip_height_out);
  endtask

  // Result side: check each beat, then hold off for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      compare_beat(out_data);
      stall_left = calm ? 0 : $urandom_range(0, 6);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 7) == 0);
    end
  end

  // Presents one header and returns the prediction once the beat is taken.
  task automatic push_header(input in_item_t h, output out_item_t v);
    in_data <= h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judge_header(h, v);
  endtask

  task automatic idle_in();
    int n;
    n = calm ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic load_difficulty(input logic [5:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chain_diff = (v < DIFF_MIN) ? DIFF_MIN : (v > DIFF_MAX) ? DIFF_MAX : v;
  endtask

  task automatic run_rows(input int first, input int last);
    in_item_t  h;
    out_item_t v;
    for (int i = first; i <= last; i++) begin
      h = plan[i].hdr;
      if (plan[i].forge) h.miner_id = steer_miner(h, plan[i].want);
      push_header(h, v);
      if (plan[i].known) begin
        v.accepted = plan[i].k_acc;
        v.stale = plan[i].k_stale;
        v.next_difficulty = plan[i].k_diff;
        v.tip_height_out = plan[i].k_tip;
      end
      post_verdict(v);
      idle_in();
    end
  endtask

  // Mostly headers that extend the chain with a steered hash; the rest is noise.
  task automatic make_header(output in_item_t h);
    logic [5:0]  d;
    logic [31:0] want;
    h.block_time = $urandom;
    h.previous_hash = $urandom;
    h.nonce_word = $urandom;
    h.miner_id = $urandom;
    h.claimed_hash = $urandom;
    if ($urandom_range(0, 99) < 75) begin
      h.block_height = chain_tip + 32'($urandom_range(1, 12));
      if ($urandom_range(0, 4) == 0) h.block_height = chain_tip + (32'sd10 - chain_tip % 32'sd10);
      case ($urandom_range(0, 9))
        7: h.header_difficulty = $urandom_range(21, 32);
        8: h.header_difficulty = $urandom_range(33, 40);
        9: h.header_difficulty = $urandom;
        default: h.header_difficulty = $urandom_range(0, 20);
      endcase
      d = (h.header_difficulty > 32'(DIFF_MAX)) ? DIFF_MAX : h.header_difficulty[5:0];
      want = $urandom;
      if ($urandom_range(0, 4) != 0) want = (d == 6'd0) ? (want & 32'h7FFF_FFFF) : (want >> d);
      h.miner_id = steer_miner(h, want);
      if ($urandom_range(0, 3) != 0) h.claimed_hash = want;
    end else begin
      h.block_height = $urandom;
      h.header_difficulty = $urandom;
      if ($urandom_range(0, 1) == 0) h.block_height = chain_tip - 32'($urandom_range(0, 50));
    end
  endtask

  initial begin
    // Stale headers, zero difficulty, saturated difficulty and retarget points.
    plan[0]  = '{'{32'sd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                 1'b0, 32'h0, 1'b1, 1'b0, 1'b1, 6'd1, 32'sd0};
    plan[1]  = '{'{32'sh8000_0000, '1, '1, '1, '1, '1, '1},
                 1'b0, 32'h0, 1'b1, 1'b0, 1'b1, 6'd1, 32'sd0};
    plan[2]  = '{'{32'sd5, 32'h5EED_0001, 32'h1234_ABCD, 32'd0, 32'h7, 32'h0, 32'h7FFF_FFFF},
                 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd1, 32'sd5};
    plan[3]  = '{'{32'sd6, 32'h5EED_0002, 32'hCAFE_0000, 32'd0, 32'h8, 32'h0, 32'h0},
                 1'b1, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd1, 32'sd5};
    plan[4]  = '{'{32'sd10, 32'h5EED_0003, 32'hAAAA_5555, 32'd32, 32'h9, 32'h0, 32'h0},
                 1'b1, 32'h0, 1'b1, 1'b1, 1'b0, 6'd2, 32'sd10};
    plan[5]  = '{'{32'sd20, 32'h5EED_0004, 32'h5555_AAAA, '1, 32'hA, 32'h0, 32'h1},
                 1'b1, 32'h1, 1'b1, 1'b0, 1'b0, 6'd2, 32'sd10};
    plan[6]  = '{'{32'sd20, 32'h5EED_0005, 32'h0F0F_F0F0, '1, 32'hB, 32'h0, 32'h0},
                 1'b1, 32'h0, 1'b1, 1'b1, 1'b0, 6'd3, 32'sd20};
    plan[7]  = '{'{32'sd20, 32'h5EED_0006, 32'h1111_2222, 32'd1, 32'hC, 32'h0, 32'h0},
                 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, 6'd3, 32'sd20};
    plan[8]  = '{'{32'sd30, 32'h5EED_0007, 32'h3333_4444, 32'd33, 32'hD, 32'h0, 32'h0},
                 1'b1, 32'h0, 1'b1, 1'b1, 1'b0, 6'd4, 32'sd30};
    plan[9]  = '{'{32'sd31, 32'h5EED_0008, 32'h5555_6666, 32'd31, 32'hE, 32'h0, 32'h1},
                 1'b1, 32'h1, 1'b1, 1'b1, 1'b0, 6'd4, 32'sd31};
    plan[10] = '{'{32'sd32, 32'h5EED_0009, 32'h7777_8888, 32'd31, 32'hF, 32'h0, 32'h2},
                 1'b1, 32'h2, 1'b1, 1'b0, 1'b0, 6'd4, 32'sd31};
    plan[11] = '{'{32'sd33, 32'h5EED_000A, 32'h9999_AAAA, 32'd1, 32'h10, 32'h0, 32'h7FFF_FFFF},
                 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd4, 32'sd33};
    plan[12] = '{'{32'sd34, 32'h5EED_000B, 32'hBBBB_CCCC, 32'd1, 32'h11, 32'h0, 32'h8000_0001},
                 1'b1, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd4, 32'sd33};
    plan[13] = '{'{32'sd35, 32'h5EED_000C, 32'hDDDD_EEEE, 32'd16, 32'h12, 32'h0, 32'h0000_FFFF},
                 1'b1, 32'h0000_FFFF, 1'b1, 1'b1, 1'b0, 6'd4, 32'sd35};
    plan[14] = '{'{32'sd36, 32'h5EED_000D, 32'hFFFF_0000, 32'd16, 32'h13, 32'h0, 32'h0001_0000},
                 1'b1, 32'h0001_0000, 1'b1, 1'b0, 1'b0, 6'd4, 32'sd35};
    plan[15] = '{'{32'sd40, 32'h5EED_000E, 32'h0000_FFFF, 32'd2, 32'h14, 32'h0, 32'hDEAD_BEEF},
                 1'b1, 32'h3FFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd5, 32'sd40};
    plan[16] = '{'{-32'sd1, 32'h5EED_000F, 32'h1357_9BDF, 32'd5, 32'h15, 32'h2468_ACE0, 32'h0},
                 1'b0, 32'h0, 1'b1, 1'b0, 1'b1, 6'd5, 32'sd40};
    // Top and bottom of the height range; these run last since nothing can follow a tip at the maximum.
    plan[17] = '{'{32'sh7FFF_FFFF, 32'h5EED_0010, 32'h2222_3333, 32'd8, 32'h16, 32'h0, 32'h0},
                 1'b1, 32'h0100_0000, 1'b0, 1'b0, 1'b0, 6'd0, 32'sd0};
    plan[18] = '{'{32'sh7FFF_FFFF, 32'h5EED_0011, 32'h4444_5555, 32'd8, 32'h17, 32'h0, 32'h00FF_FFFF},
                 1'b1, 32'h00FF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 32'sd0};
    plan[19] = '{'{32'sh7FFF_FFFF, '1, '1, '1, '1, '1, '1},
                 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 6'd0, 32'sd0};
    plan[20] = '{'{32'sh8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 6'd0, 32'sd0};
  end

  initial begin
    in_item_t   h;
    out_item_t  v;
    logic [5:0] setting;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_rows(0, HEAD_ROWS - 1);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = 6'd63;
        1: setting = 6'd0;
        2: setting = DIFF_MAX;
        3: setting = 6'd31;
        4: setting = 6'd33;
        5: setting = DIFF_MIN;
        default: setting = 6'($urandom_range(0, 63));
      endcase
      load_difficulty(setting);
      calm = (p % 3 == 2);
      for (int i = 0; i < PER_PHASE; i++) begin
        make_header(h);
        push_header(h, v);
        post_verdict(v);
        idle_in();
      end
    end
    calm = 1'b0;
    run_rows(HEAD_ROWS, ROWS - 1);
    wait_drained();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
